FILE: sv/mi3_pkg.sv
package mi3_pkg;

    // Number format
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 28;
    localparam int DET_BITS  = 48;

    // Derived widths: cofactor, determinant, divider
    localparam int CW = 2 * WORD_BITS + 1;
    localparam int DW = 3 * WORD_BITS + 2;
    localparam int AW = DW;
    localparam int NW = CW + 2 * FRAC_BITS;
    localparam int QB = WORD_BITS + 1;
    localparam int HW = NW - QB;
    localparam int XW = (HW > AW) ? HW : AW;
    localparam int QDW = DW + 1;
    localparam int SW = ((QDW > DET_BITS) ? QDW : DET_BITS) + 1;
    localparam int STEP_BITS = $clog2(QB);
    localparam int QUEUE_DEPTH = 2;

    // Cofactor k = m[CofA]*m[CofB] - m[CofC]*m[CofD], m indexed row*3+col
    localparam int CofA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CofB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CofC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CofD [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic signed [WORD_BITS-1:0] e00;
        logic signed [WORD_BITS-1:0] e01;
        logic signed [WORD_BITS-1:0] e02;
        logic signed [WORD_BITS-1:0] e10;
        logic signed [WORD_BITS-1:0] e11;
        logic signed [WORD_BITS-1:0] e12;
        logic signed [WORD_BITS-1:0] e20;
        logic signed [WORD_BITS-1:0] e21;
        logic signed [WORD_BITS-1:0] e22;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] r00;
        logic signed [WORD_BITS-1:0] r01;
        logic signed [WORD_BITS-1:0] r02;
        logic signed [WORD_BITS-1:0] r10;
        logic signed [WORD_BITS-1:0] r11;
        logic signed [WORD_BITS-1:0] r12;
        logic signed [WORD_BITS-1:0] r20;
        logic signed [WORD_BITS-1:0] r21;
        logic signed [WORD_BITS-1:0] r22;
        logic signed [DET_BITS-1:0]  det_value;
        logic                        singular;
        logic                        overflow;
    } t_out_item;

    typedef struct packed {
        logic [8:0][CW-1:0] cof;
        logic [DW-1:0]      det;
    } t_job;

    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctl;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_DONE
    } t_bstate;

endpackage

FILE: sv/matrix_inverse_3x3.sv
// Path from input transaction to result valid: input register, then
// 4 more front stages, queue write, 1 load, 33 restoring division steps, 1 hand-off.
// The divider lanes set the pace: they step one quotient bit per cycle over 33 bits
// and take the next matrix only when done; the front accepts until the queue is full.
// Reset (synchronous, active low) clears valids, queue and sequencer state.
module matrix_inverse_3x3
    import mi3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic w_push;
    logic w_q_ready;
    logic w_q_valid;
    logic w_pop;
    t_job w_job;
    t_job w_head;

    mi3_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_push    (w_push),
        .i_q_ready (w_q_ready),
        .o_job     (w_job)
    );

    mi3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_job   (w_job),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    mi3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_head    (w_head),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

FILE: sv/mi3_front.sv
module mi3_front
    import mi3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    output logic     o_push,
    input  logic     i_q_ready,
    output t_job     o_job
);

    logic [4:0] r_v;
    logic       w_en;
    t_in_item   r_in;
    logic signed [WORD_BITS-1:0] w_m [9];
    logic signed [2*WORD_BITS-1:0] r_pa [9];
    logic signed [2*WORD_BITS-1:0] r_pb [9];
    logic signed [WORD_BITS-1:0] r_r0a [3];
    logic signed [WORD_BITS-1:0] r_r0b [3];
    logic signed [CW-1:0] r_cof [9];
    logic signed [CW-1:0] r_cof2 [9];
    logic signed [2*WORD_BITS:0] r_lo [3];
    logic signed [2*WORD_BITS:0] r_hi [3];
    logic signed [DW-1:0] w_det;
    t_job r_job;

    // Advance the whole pipe unless the last stage is blocked
    assign w_en    = !r_v[4] || i_q_ready;
    assign o_ready = w_en;
    assign o_push  = r_v[4];
    assign o_job   = r_job;

    assign w_m[0] = r_in.e00;
    assign w_m[1] = r_in.e01;
    assign w_m[2] = r_in.e02;
    assign w_m[3] = r_in.e10;
    assign w_m[4] = r_in.e11;
    assign w_m[5] = r_in.e12;
    assign w_m[6] = r_in.e20;
    assign w_m[7] = r_in.e21;
    assign w_m[8] = r_in.e22;

    // Sum the three row-0 partial products into the determinant
    always_comb begin
        w_det = '0;
        for (int j = 0; j < 3; j++) begin
            w_det = w_det + (DW'(r_hi[j]) <<< WORD_BITS) + DW'(r_lo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_data;
            // Products for the cofactors
            for (int k = 0; k < 9; k++) begin
                r_pa[k] <= (2*WORD_BITS)'(w_m[CofA[k]]) * (2*WORD_BITS)'(w_m[CofB[k]]);
                r_pb[k] <= (2*WORD_BITS)'(w_m[CofC[k]]) * (2*WORD_BITS)'(w_m[CofD[k]]);
            end
            for (int j = 0; j < 3; j++) begin
                r_r0a[j] <= w_m[j];
                r_r0b[j] <= r_r0a[j];
            end
            // Cofactors
            for (int k = 0; k < 9; k++) begin
                r_cof[k]  <= CW'(r_pa[k]) - CW'(r_pb[k]);
                r_cof2[k] <= r_cof[k];
            end
            // Split each expansion product into low and high halves
            for (int j = 0; j < 3; j++) begin
                r_lo[j] <= (2*WORD_BITS+1)'(r_r0b[j])
                         * (2*WORD_BITS+1)'($signed({1'b0, r_cof[3*j][WORD_BITS-1:0]}));
                r_hi[j] <= (2*WORD_BITS+1)'(r_r0b[j])
                         * (2*WORD_BITS+1)'($signed(r_cof[3*j][CW-1:WORD_BITS]));
            end
            for (int k = 0; k < 9; k++) begin
                r_job.cof[k] <= r_cof2[k];
            end
            r_job.det <= w_det;
        end
    end

endmodule

FILE: sv/mi3_queue.sv
module mi3_queue
    import mi3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_head
);

    localparam int PB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CB = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PB-1:0] r_wr;
    logic [PB-1:0] r_rd;
    logic [CB-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_ready = (r_cnt != CB'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == PB'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == PB'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/mi3_lane.sv
module mi3_lane
    import mi3_pkg::*;
(
    input  logic                 i_clk,
    input  t_lane_ctl            i_ctl,
    input  logic [CW-1:0]        i_cof,
    input  logic                 i_det_neg,
    input  logic [AW-1:0]        i_ad,
    output logic [WORD_BITS-1:0] o_res,
    output logic                 o_ovf
);

    logic [AW-1:0] r_rem;
    logic [QB-1:0] r_nlo;
    logic [QB-1:0] r_q;
    logic          r_pre;
    logic          r_neg;

    logic [CW-1:0] w_an;
    logic [NW-1:0] w_n;
    logic [AW:0]   w_sh;
    logic          w_ge;
    logic          w_up;
    logic [QB:0]   w_qr;
    logic [QB:0]   w_half;

    // Magnitude of the cofactor scaled by two fraction widths
    assign w_an = i_cof[CW-1] ? (~i_cof + 1'b1) : i_cof;
    assign w_n  = {w_an, {(2*FRAC_BITS){1'b0}}};

    // One restoring division step
    assign w_sh = {r_rem, r_nlo[QB-1]};
    assign w_ge = (w_sh >= {1'b0, i_ad});

    // Round half away from zero, then saturate
    assign w_up   = ({r_rem, 1'b0} >= {1'b0, i_ad});
    assign w_qr   = {1'b0, r_q} + (QB+1)'(w_up);
    assign w_half = (QB+1)'(1) << (WORD_BITS - 1);

    always_comb begin
        if (r_neg) begin
            o_ovf = r_pre || (w_qr > w_half);
            o_res = o_ovf ? w_half[WORD_BITS-1:0] : (~w_qr[WORD_BITS-1:0] + 1'b1);
        end else begin
            o_ovf = r_pre || (w_qr >= w_half);
            o_res = o_ovf ? (w_half[WORD_BITS-1:0] - 1'b1) : w_qr[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pre <= (XW'(w_n[NW-1:QB]) >= XW'(i_ad));
            r_rem <= AW'(w_n[NW-1:QB]);
            r_nlo <= w_n[QB-1:0];
            r_q   <= '0;
            r_neg <= i_cof[CW-1] ^ i_det_neg;
        end else if (i_ctl.step) begin
            r_rem <= w_ge ? AW'(w_sh - {1'b0, i_ad}) : w_sh[AW-1:0];
            r_nlo <= r_nlo << 1;
            r_q   <= {r_q[QB-2:0], w_ge};
        end
    end

endmodule

FILE: sv/mi3_back.sv
module mi3_back
    import mi3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_bstate              r_state;
    t_bstate              n_state;
    logic [STEP_BITS-1:0] r_cnt;
    logic [STEP_BITS-1:0] n_cnt;
    logic [AW-1:0]        r_ad;
    logic                 r_dneg;
    logic                 r_sing;
    logic [DET_BITS-1:0]  r_detv;
    logic                 r_dovf;
    logic                 r_ov;
    t_out_item            r_out;
    t_lane_ctl            w_ctl;
    logic                 w_wout;

    logic                 w_hneg;
    logic [AW-1:0]        w_had;
    logic [AW-1:0]        w_ad;
    logic [DW:0]          w_dsum;
    logic [SW-1:0]        w_qd;
    logic [SW-1:0]        w_dhalf;
    logic                 w_dovf;
    logic [DET_BITS-1:0]  w_detv;

    logic [WORD_BITS-1:0] w_res [9];
    logic [8:0]           w_ovf;
    logic [WORD_BITS-1:0] w_r   [9];

    // Magnitude of the queued determinant
    assign w_hneg = i_head.det[DW-1];
    assign w_had  = w_hneg ? (~i_head.det + 1'b1) : i_head.det;
    assign w_ad   = (r_state == B_IDLE) ? w_had : r_ad;

    // Round the determinant to the output scale and saturate
    assign w_dsum  = (DW+1)'(w_had) + ((DW+1)'(1) << (2*FRAC_BITS - 1));
    assign w_qd    = SW'(w_dsum >> (2*FRAC_BITS));
    assign w_dhalf = SW'(1) << (DET_BITS - 1);

    always_comb begin
        if (w_hneg) begin
            w_dovf = (w_qd > w_dhalf);
            w_detv = w_dovf ? w_dhalf[DET_BITS-1:0] : (~w_qd[DET_BITS-1:0] + 1'b1);
        end else begin
            w_dovf = (w_qd >= w_dhalf);
            w_detv = w_dovf ? (w_dhalf[DET_BITS-1:0] - 1'b1) : w_qd[DET_BITS-1:0];
        end
    end

    // Divider lanes, one per inverse entry
    for (genvar k = 0; k < 9; k++) begin : g_lane
        mi3_lane u_lane (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_cof     (i_head.cof[k]),
            .i_det_neg ((r_state == B_IDLE) ? w_hneg : r_dneg),
            .i_ad      (w_ad),
            .o_res     (w_res[k]),
            .o_ovf     (w_ovf[k])
        );
        assign w_r[k] = r_sing ? '0 : w_res[k];
    end

    // Sequence load, division steps and hand-off
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        o_pop    = 1'b0;
        w_ctl    = '0;
        w_wout   = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_pop      = 1'b1;
                    w_ctl.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = B_RUN;
                end
            end
            B_RUN: begin
                w_ctl.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == STEP_BITS'(QB - 1)) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (!r_ov || i_ready) begin
                    w_wout  = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_wout) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Hold per-transaction determinant data and the output register
    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_ad   <= w_had;
            r_dneg <= w_hneg;
            r_sing <= (i_head.det == '0);
            r_detv <= w_detv;
            r_dovf <= w_dovf;
        end
        if (w_wout) begin
            r_out.r00       <= w_r[0];
            r_out.r01       <= w_r[1];
            r_out.r02       <= w_r[2];
            r_out.r10       <= w_r[3];
            r_out.r11       <= w_r[4];
            r_out.r12       <= w_r[5];
            r_out.r20       <= w_r[6];
            r_out.r21       <= w_r[7];
            r_out.r22       <= w_r[8];
            r_out.det_value <= r_sing ? '0 : r_detv;
            r_out.singular  <= r_sing;
            r_out.overflow  <= !r_sing && ((|w_ovf) || r_dovf);
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

FILE: sv/mi3_checker.sv
module mi3_checker
    import mi3_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    logic [4:0] r_open;
    logic       w_in;
    logic       w_out;

    assign w_in  = i_valid && o_ready;
    assign w_out = o_valid && i_ready;

    // Track transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (w_in && !w_out) begin
            r_open <= r_open + 1'b1;
        end else if (w_out && !w_in) begin
            r_open <= r_open - 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out |-> r_open != '0)
        else $error("result without an accepted transaction");

    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |-> o_data.overflow == 1'b0
            && o_data.det_value == '0 && o_data.r00 == '0 && o_data.r22 == '0)
        else $error("singular result carries data");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

FILE: verif/matrix_inverse_3x3_tb.sv
`timescale 1ns / 1ps

module matrix_inverse_3x3_tb;
    import mi3_pkg::*;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        t_in_item  mat;
        bit        known;
        t_out_item inv;
    } t_row;

    localparam logic signed [WORD_BITS-1:0] ONE  = 1 <<< FRAC_BITS;
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam int RANDOM_ITEMS  = 1335;
    localparam int QUIET_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int WATCHDOG_MAX  = 5000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    t_out_item inverse_q [$];
    int        errors    = 0;
    int        idle_cnt  = 0;
    bit        idle_on   = 1'b1;
    bit        long_hold = 1'b0;

    matrix_inverse_3x3 u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Round to nearest, ties away from zero
    function automatic t_wide round_div(t_wide n, t_wide d);
        t_wide an, ad, q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q  = ((an <<< 1) + ad) / (ad <<< 1);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic t_wide clamp(t_wide a, int bits, inout bit ovf);
        t_wide hi, lo;
        hi = (t_wide'(1) <<< (bits - 1)) - 1;
        lo = -(t_wide'(1) <<< (bits - 1));
        if (a > hi) begin
            ovf = 1'b1;
            return hi;
        end
        if (a < lo) begin
            ovf = 1'b1;
            return lo;
        end
        return a;
    endfunction

    // Exact adjugate inverse of one matrix
    function automatic t_out_item invert(t_in_item x);
        t_wide     m [9];
        t_wide     c [9];
        t_wide     det, r;
        t_out_item y;
        bit        ovf;
        m[0] = x.e00; m[1] = x.e01; m[2] = x.e02;
        m[3] = x.e10; m[4] = x.e11; m[5] = x.e12;
        m[6] = x.e20; m[7] = x.e21; m[8] = x.e22;
        c[0] = m[4] * m[8] - m[5] * m[7];
        c[1] = m[2] * m[7] - m[1] * m[8];
        c[2] = m[1] * m[5] - m[2] * m[4];
        c[3] = m[5] * m[6] - m[3] * m[8];
        c[4] = m[0] * m[8] - m[2] * m[6];
        c[5] = m[2] * m[3] - m[0] * m[5];
        c[6] = m[3] * m[7] - m[4] * m[6];
        c[7] = m[1] * m[6] - m[0] * m[7];
        c[8] = m[0] * m[4] - m[1] * m[3];
        det  = m[0] * c[0] + m[1] * c[3] + m[2] * c[6];
        y    = '0;
        ovf  = 1'b0;
        if (det == 0) begin
            y.singular = 1'b1;
            return y;
        end
        for (int k = 0; k < 9; k++) begin
            r = clamp(round_div(c[k] <<< (2 * FRAC_BITS), det), WORD_BITS, ovf);
            y[$bits(t_out_item) - 1 - WORD_BITS * k -: WORD_BITS] = r[WORD_BITS-1:0];
        end
        r = clamp(round_div(det, t_wide'(1) <<< (2 * FRAC_BITS)), DET_BITS, ovf);
        y.det_value = r[DET_BITS-1:0];
        y.overflow  = ovf;
        return y;
    endfunction

    function automatic t_in_item diag(logic signed [WORD_BITS-1:0] a, b, c);
        t_in_item x;
        x     = '0;
        x.e00 = a;
        x.e11 = b;
        x.e22 = c;
        return x;
    endfunction

    function automatic logic signed [WORD_BITS-1:0] pick_entry(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 1 << 30) - (1 << 29);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 0;
                    1: return ONE;
                    2: return -ONE;
                    3: return WMAX;
                    default: return WMIN;
                endcase
            end
        endcase
    endfunction

    // Mix full-range, moderate, corner-value and singular matrices
    function automatic t_in_item random_matrix();
        t_in_item x;
        int       mode;
        mode = $urandom_range(0, 9);
        x = {pick_entry(mode % 3), pick_entry(mode % 3), pick_entry(mode % 3),
             pick_entry(mode % 3), pick_entry(mode % 3), pick_entry(mode % 3),
             pick_entry(mode % 3), pick_entry(mode % 3), pick_entry(mode % 3)};
        if (mode == 9) begin
            x.e20 = x.e00;
            x.e21 = x.e01;
            x.e22 = x.e02;
        end
        if (mode == 8) begin
            x.e01 = 0;
            x.e11 = 0;
            x.e21 = 0;
        end
        return x;
    endfunction

    // Drive one transaction and hold it until accepted
    task automatic offer(t_in_item x);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= x;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Record each accepted matrix as its expected inverse
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            inverse_q.push_back(invert(i_data));
        end
    end

    // Compare each result against the oldest expected inverse
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (inverse_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                errors++;
            end else begin
                want = inverse_q.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (want[$bits(t_out_item) - 1 - WORD_BITS * k -: WORD_BITS] !==
                        o_data[$bits(t_out_item) - 1 - WORD_BITS * k -: WORD_BITS]) begin
                        $display("%0t: entry %0d expected %h actual %h", $time, k,
                            want[$bits(t_out_item) - 1 - WORD_BITS * k -: WORD_BITS],
                            o_data[$bits(t_out_item) - 1 - WORD_BITS * k -: WORD_BITS]);
                        errors++;
                    end
                end
                if (want.det_value !== o_data.det_value) begin
                    $display("%0t: det_value expected %h actual %h", $time,
                             want.det_value, o_data.det_value);
                    errors++;
                end
                if (want.singular !== o_data.singular) begin
                    $display("%0t: singular expected %b actual %b", $time,
                             want.singular, o_data.singular);
                    errors++;
                end
                if (want.overflow !== o_data.overflow) begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             want.overflow, o_data.overflow);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG_MAX) begin
            $display("FAIL matrix_inverse_3x3");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        t_row      rows [$];
        t_out_item y;
        t_in_item  x;

        // zero matrix is singular
        y = '0;
        y.singular = 1'b1;
        rows.push_back('{'0, 1'b1, y});
        // identity and its negation invert to themselves
        y = '0;
        y.r00 = ONE; y.r11 = ONE; y.r22 = ONE;
        y.det_value = ONE;
        rows.push_back('{diag(ONE, ONE, ONE), 1'b1, y});
        y = '0;
        y.r00 = -ONE; y.r11 = -ONE; y.r22 = -ONE;
        y.det_value = -ONE;
        rows.push_back('{diag(-ONE, -ONE, -ONE), 1'b1, y});
        // tiny determinant: rounds to zero, inverse saturates
        y = '0;
        y.r00 = WMAX; y.r11 = WMAX; y.r22 = WMAX;
        y.overflow = 1'b1;
        rows.push_back('{diag(1, 1, 1), 1'b1, y});
        // all entries equal (either extreme, or all ones) are singular
        y = '0;
        y.singular = 1'b1;
        rows.push_back('{{9{WMAX}}, 1'b1, y});
        rows.push_back('{{9{WMIN}}, 1'b1, y});
        rows.push_back('{{9{32'hFFFF_FFFF}}, 1'b1, y});
        // predicted rows: negative saturation, large diagonals, mixed extremes
        rows.push_back('{diag(-1, 1, 1), 1'b0, y});
        rows.push_back('{diag(WMAX, WMAX, WMAX), 1'b0, y});
        rows.push_back('{diag(WMIN, WMIN, WMIN), 1'b0, y});
        rows.push_back('{diag(WMIN, WMAX, -ONE), 1'b0, y});
        rows.push_back('{{WMAX, WMIN, 32'sd0, WMIN, WMAX, WMIN, 32'sd0, WMIN, WMAX},
                         1'b0, y});
        rows.push_back('{{ONE, ONE, 32'sd0, 32'sd0, ONE, ONE, ONE, 32'sd0, ONE}, 1'b0, y});
        rows.push_back('{{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8765_4321,
                          32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_0001, 32'h8000_FFFF,
                          32'h0000_0003}, 1'b0, y});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (rows[n]) begin
            if (rows[n].known && invert(rows[n].mat) !== rows[n].inv) begin
                $display("%0t: table row %0d expected %h actual %h", $time, n,
                         rows[n].inv, invert(rows[n].mat));
                errors++;
            end
            offer(rows[n].mat);
        end

        // Wait out all results, then back up the block behind a stalled receiver
        i_valid <= 1'b0;
        wait (inverse_q.size() == 0);
        @(posedge i_clk);
        long_hold = 1'b1;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                i_valid <= 1'b0;
                wait (inverse_q.size() == 0);
                @(posedge i_clk);
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
            x = random_matrix();
            offer(x);
        end
        i_valid <= 1'b0;

        wait (inverse_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS matrix_inverse_3x3");
        end else begin
            $display("FAIL matrix_inverse_3x3");
        end
        $finish;
    end

endmodule
